FILE: src/csm_pkg.sv
// Shared types, constants and helpers for the clock skew monitor.
// No dependencies; every other file imports this package.
package csm_pkg;

    // Significant width of both counters; the mask below follows from it.
    localparam int CntWidth = 64;
    localparam logic [63:0] CntMask = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - CntWidth);

    // Configuration register indexes
    localparam logic [2:0] CfgMonMask   = 3'd0;
    localparam logic [2:0] CfgMonMult   = 3'd1;
    localparam logic [2:0] CfgMonShift  = 3'd2;
    localparam logic [2:0] CfgRefMask   = 3'd3;
    localparam logic [2:0] CfgRefMult   = 3'd4;
    localparam logic [2:0] CfgRefShift  = 3'd5;
    localparam logic [2:0] CfgMargin    = 3'd6;
    localparam logic [2:0] CfgReadLimit = 3'd7;

    // Result status codes
    localparam logic [2:0] StReject   = 3'd0;
    localparam logic [2:0] StPrimed   = 3'd1;
    localparam logic [2:0] StWithin   = 3'd2;
    localparam logic [2:0] StExceeded = 3'd3;
    localparam logic [2:0] StShortest = 3'd4;

    // Register reset values
    localparam logic [63:0] RstMask   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] RstMult   = 32'd1;
    localparam logic [31:0] RstMargin = 32'd100000;   // 100 us
    localparam logic [31:0] RstLimit  = 32'd100000;

    typedef struct packed {
        logic [63:0] mon_count;
        logic [63:0] ref_count;
        logic [63:0] ref_count_after;
        logic [63:0] sample_time_ns;
    } t_in_req;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [63:0] mon_elapsed_ns;
        logic signed [63:0] ref_elapsed_ns;
        logic [63:0]        skew_total_ns;
        logic [31:0]        overflow_total;
        logic [63:0]        shortest_ns;
    } t_out_req;

    // Partial products of a 64x32 multiply, low 64 bits kept:
    // lo = delta[31:0] * mult, hi = low half of delta[63:32] * mult.
    typedef struct packed {
        logic [63:0] lo;
        logic [31:0] hi;
    } t_part;

    function automatic logic [63:0] to_ns(input t_part p, input logic [5:0] sh);
        logic [63:0] prod;
        prod = p.lo + {p.hi, 32'b0};
        return prod >> sh;
    endfunction

endpackage

FILE: src/clock_skew_monitor_top.sv
// Clock skew monitor: two-stage datapath, state update and result register.
// Depends on csm_pkg and csm_ns_front.
// An accepted request waits in r_in; stage 1 registers it with its partial products,
//   stage 2 writes the result register. The baseline registers written in stage 2
//   feed the delta multiplies of stage 1, so stage 1 starts only on an empty stage 2.
// The result register frees the input side while a result waits to be taken.
// Reset (sync, active low) empties the pipeline, clears the state and loads the
//   register defaults.
module clock_skew_monitor_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  csm_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output csm_pkg::t_out_req o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data
);
    import csm_pkg::*;

    // configuration
    logic [63:0] r_mon_mask, r_ref_mask;
    logic [31:0] r_mon_mult, r_ref_mult, r_margin, r_read_limit;
    logic [5:0]  r_mon_shift, r_ref_shift;

    // monitor state
    logic [63:0] r_mon_base, r_ref_base, r_base_time, r_acc, r_short;
    logic [31:0] r_ovf;
    logic        r_primed;

    // pipeline
    logic     r_in_vld, r_p_vld, r_out_vld;
    t_in_req  r_in, r_p_req;
    t_part    r_p_win, r_p_ref, r_p_mon;
    t_out_req r_out;

    logic  w_adv1, w_adv2;
    t_part w_win_part, w_ref_part, w_mon_part;

    assign w_adv1     = r_in_vld && !r_p_vld;
    assign w_adv2     = r_p_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mon_mask   <= RstMask;
            r_mon_mult   <= RstMult;
            r_mon_shift  <= '0;
            r_ref_mask   <= RstMask;
            r_ref_mult   <= RstMult;
            r_ref_shift  <= '0;
            r_margin     <= RstMargin;
            r_read_limit <= RstLimit;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgMonMask:   r_mon_mask   <= i_cfg_data;
                CfgMonMult:   r_mon_mult   <= i_cfg_data[31:0];
                CfgMonShift:  r_mon_shift  <= i_cfg_data[5:0];
                CfgRefMask:   r_ref_mask   <= i_cfg_data;
                CfgRefMult:   r_ref_mult   <= i_cfg_data[31:0];
                CfgRefShift:  r_ref_shift  <= i_cfg_data[5:0];
                CfgMargin:    r_margin     <= i_cfg_data[31:0];
                CfgReadLimit: r_read_limit <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ---- stage 1: deltas and partial products
    csm_ns_front u_win (
        .i_now  (r_in.ref_count_after),
        .i_last (r_in.ref_count),
        .i_mask (r_ref_mask),
        .i_mult (r_ref_mult),
        .o_part (w_win_part)
    );

    csm_ns_front u_ref (
        .i_now  (r_in.ref_count),
        .i_last (r_ref_base),
        .i_mask (r_ref_mask),
        .i_mult (r_ref_mult),
        .o_part (w_ref_part)
    );

    csm_ns_front u_mon (
        .i_now  (r_in.mon_count),
        .i_last (r_mon_base),
        .i_mask (r_mon_mask),
        .i_mult (r_mon_mult),
        .o_part (w_mon_part)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_p_vld  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv1) begin
                r_p_vld <= 1'b1;
            end else if (w_adv2) begin
                r_p_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_adv1) begin
            r_p_req <= r_in;
            r_p_win <= w_win_part;
            r_p_ref <= w_ref_part;
            r_p_mon <= w_mon_part;
        end
    end

    // ---- stage 2: conversion, skew accumulation, state update
    logic [63:0] w_win, w_ref_ns, w_mon_ns, w_diff, w_mag, w_sum, w_gap;
    logic        w_win_ok, w_exceed, w_new_short;

    logic [2:0]  n_status;
    logic [63:0] n_mon_ns, n_ref_ns, n_total;
    logic [63:0] n_acc, n_short;
    logic [31:0] n_ovf;
    logic        n_primed, n_rebase;

    always_comb begin
        w_win       = to_ns(r_p_win, r_ref_shift);
        w_win_ok    = w_win[63] || (w_win <= {32'b0, r_read_limit});
        w_ref_ns    = to_ns(r_p_ref, r_ref_shift);
        w_mon_ns    = to_ns(r_p_mon, r_mon_shift);
        w_diff      = w_mon_ns - w_ref_ns;
        w_mag       = w_diff[63] ? (64'd0 - w_diff) : w_diff;
        w_sum       = r_acc + w_mag;
        w_exceed    = w_sum > {32'b0, r_margin};
        w_gap       = r_p_req.sample_time_ns - r_base_time;
        w_new_short = w_gap < r_short;

        n_status = StReject;
        n_mon_ns = '0;
        n_ref_ns = '0;
        n_total  = r_acc;
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        n_short  = r_short;
        n_primed = r_primed;
        n_rebase = 1'b0;

        if (!w_win_ok) begin
            n_status = StReject;
        end else if (!r_primed) begin
            n_status = StPrimed;
            n_primed = 1'b1;
            n_rebase = 1'b1;
        end else begin
            n_mon_ns = w_mon_ns;
            n_ref_ns = w_ref_ns;
            n_total  = w_sum;
            if (w_exceed) begin
                n_ovf    = r_ovf + 32'd1;
                n_acc    = '0;
                n_rebase = 1'b1;
                if (w_new_short) begin
                    n_short  = w_gap;
                    n_status = StShortest;
                end else begin
                    n_status = StExceeded;
                end
            end else begin
                n_acc    = w_sum;
                n_status = StWithin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mon_base  <= '0;
            r_ref_base  <= '0;
            r_base_time <= '0;
            r_acc       <= '0;
            r_ovf       <= '0;
            r_short     <= '1;
            r_primed    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (w_adv2) begin
                r_acc     <= n_acc;
                r_ovf     <= n_ovf;
                r_short   <= n_short;
                r_primed  <= n_primed;
                r_out_vld <= 1'b1;
                if (n_rebase) begin
                    r_mon_base  <= r_p_req.mon_count;
                    r_ref_base  <= r_p_req.ref_count;
                    r_base_time <= r_p_req.sample_time_ns;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_out.status         <= n_status;
            r_out.mon_elapsed_ns <= n_mon_ns;
            r_out.ref_elapsed_ns <= n_ref_ns;
            r_out.skew_total_ns  <= n_total;
            r_out.overflow_total <= n_ovf;
            r_out.shortest_ns    <= n_short;
        end
    end

    // ---- checks
    a_base_only_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_mon_base) |-> $past(w_adv2))
        else $error("baseline moved without a stage-2 step");

    a_ovf_only_on_exceed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_ovf) |-> $past(w_adv2 && r_primed && w_exceed))
        else $error("overflow count changed without an exceeded sample");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv2 && (n_status == StExceeded || n_status == StShortest) |=> r_acc == 64'd0)
        else $error("accumulator not cleared after overflow");

    a_short_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_short <= $past(r_short))
        else $error("shortest interval grew");

    a_stage_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv1 |=> r_p_vld && !$past(r_p_vld))
        else $error("stage 1 computed while stage 2 was occupied");

endmodule

FILE: src/csm_ns_front.sv
// Masked counter delta and the two 32x32 partial products of its ns conversion.
// Depends on csm_pkg.
module csm_ns_front (
    input  logic [63:0]    i_now,
    input  logic [63:0]    i_last,
    input  logic [63:0]    i_mask,
    input  logic [31:0]    i_mult,
    output csm_pkg::t_part o_part
);
    import csm_pkg::*;

    logic [63:0] w_m;
    logic [63:0] w_d;
    logic [63:0] w_delta;
    logic [63:0] w_lo;

    assign w_m = i_mask & CntMask;
    assign w_d = (i_now - i_last) & w_m;
    // a delta reaching the mask MSB is taken as a backwards step
    assign w_delta = (|(w_d & ~(w_m >> 1))) ? 64'd0 : w_d;

    assign w_lo        = w_delta[31:0] * i_mult;
    assign o_part.lo   = w_lo;
    assign o_part.hi   = w_delta[63:32] * i_mult;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for clock_skew_monitor_top: a directed sample table, then fixed and
// randomized configuration phases; typed rows checked against the table, others against
// an in-bench skew model. Depends on csm_pkg and the RTL under src; reads no files.
module tb;
    import csm_pkg::*;

    localparam int StallLimit = 2000;
    localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [63:0] mon_mask;
        logic [31:0] mon_mult;
        logic [5:0]  mon_shift;
        logic [63:0] ref_mask;
        logic [31:0] ref_mult;
        logic [5:0]  ref_shift;
        logic [31:0] margin;
        logic [31:0] read_limit;
    } t_setup;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_req rep;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_req     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_req    o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = CfgMonMask;
    logic [63:0] i_cfg_data = '0;

    // skew model state and its copy of the registers
    t_setup      cfg;
    logic [63:0] base_mon, base_ref, base_stamp, skew_sum, shortest_gap_ns;
    logic [31:0] overflow_seen;
    bit          primed_flag;

    // counters of the sample generator
    logic [63:0] gen_mon = 64'd0, gen_ref = 64'd0, gen_stamp = 64'd0;

    t_out_req    skew_reports[$];
    t_row        plan[$];
    int          fault_count = 0;
    int          burst_left = 8;
    int          quiet_cycles = 0;
    int          rx_tick = 0;
    int          rx_mode = 0;

    clock_skew_monitor_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Masked counter delta; a delta reaching the top valid bit counts as a
    // backward step and is dropped.
    function automatic logic [63:0] span_of(input logic [63:0] now, input logic [63:0] last,
                                            input logic [63:0] mask);
        logic [63:0] m, d;
        m = mask & CntMask;
        d = (now - last) & m;
        return ((d & ~(m >> 1)) != 64'd0) ? 64'd0 : d;
    endfunction

    function automatic logic [63:0] cycles_ns(input logic [63:0] cyc, input logic [31:0] mult,
                                              input logic [5:0] sh);
        logic [63:0] prod;
        prod = cyc * {32'd0, mult};
        return prod >> sh;
    endfunction

    function automatic t_out_req monitor_sample(input t_in_req s);
        t_out_req    r;
        logic [63:0] win, mon_ns, ref_ns, diff, mag, gap;
        mon_ns = '0;
        ref_ns = '0;
        r.skew_total_ns = skew_sum;
        win = cycles_ns(span_of(s.ref_count_after, s.ref_count, cfg.ref_mask),
                        cfg.ref_mult, cfg.ref_shift);
        // window is a signed compare: bit 63 set reads as negative and passes
        if (!win[63] && win > {32'd0, cfg.read_limit}) begin
            r.status = StReject;
        end else if (!primed_flag) begin
            primed_flag = 1'b1;
            base_mon    = s.mon_count;
            base_ref    = s.ref_count;
            base_stamp  = s.sample_time_ns;
            r.status    = StPrimed;
        end else begin
            ref_ns = cycles_ns(span_of(s.ref_count, base_ref, cfg.ref_mask),
                               cfg.ref_mult, cfg.ref_shift);
            mon_ns = cycles_ns(span_of(s.mon_count, base_mon, cfg.mon_mask),
                               cfg.mon_mult, cfg.mon_shift);
            diff = mon_ns - ref_ns;
            mag  = diff[63] ? (64'd0 - diff) : diff;
            skew_sum = skew_sum + mag;
            r.skew_total_ns = skew_sum;
            if (skew_sum > {32'd0, cfg.margin}) begin
                gap = s.sample_time_ns - base_stamp;
                overflow_seen = overflow_seen + 32'd1;
                r.status = StExceeded;
                if (gap < shortest_gap_ns) begin
                    shortest_gap_ns = gap;
                    r.status = StShortest;
                end
                base_mon   = s.mon_count;
                base_ref   = s.ref_count;
                base_stamp = s.sample_time_ns;
                skew_sum   = '0;
            end else begin
                r.status = StWithin;
            end
        end
        r.mon_elapsed_ns = mon_ns;
        r.ref_elapsed_ns = ref_ns;
        r.overflow_total = overflow_seen;
        r.shortest_ns    = shortest_gap_ns;
        return r;
    endfunction

    function automatic t_setup default_setup();
        t_setup s;
        s.mon_mask   = RstMask;
        s.mon_mult   = RstMult;
        s.mon_shift  = 6'd0;
        s.ref_mask   = RstMask;
        s.ref_mult   = RstMult;
        s.ref_shift  = 6'd0;
        s.margin     = RstMargin;
        s.read_limit = RstLimit;
        return s;
    endfunction

    function automatic logic [63:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return AllOnes;
            1: return AllOnes >> $urandom_range(0, 63);
            2: return rand64();
            default: return AllOnes >> $urandom_range(32, 48);
        endcase
    endfunction

    function automatic logic [31:0] pick_mult();
        case ($urandom_range(0, 2))
            0: return 32'd1;
            1: return $urandom;
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [5:0] pick_shift();
        return $urandom_range(0, 1) ? 6'($urandom_range(0, 12)) : 6'($urandom_range(0, 63));
    endfunction

    function automatic t_setup phase_setup(input int p);
        t_setup s;
        s = default_setup();
        case (p)
            0: ;
            1: begin
                s.mon_mult = 32'd3;
                s.mon_shift = 6'd1;
                s.margin = 32'd50000;
                s.read_limit = 32'd2000;
            end
            2: begin
                s.mon_mask = 64'h0000_0000_FFFF_FFFF;
                s.ref_mask = 64'h0000_0000_FFFF_FFFF;
            end
            3: begin
                s.mon_mask = '0;
                s.ref_mask = '0;
                s.margin = '0;
                s.read_limit = '0;
            end
            4: begin
                s.mon_mult = '1;
                s.ref_mult = '1;
                s.mon_shift = 6'd32;
                s.ref_shift = 6'd32;
                s.margin = '1;
                s.read_limit = '1;
            end
            5: begin
                // large converted windows land on bit 63 and pass the limit
                s.mon_mult = '1;
                s.mon_shift = 6'd63;
                s.ref_mult = '1;
                s.margin = '0;
                s.read_limit = '0;
            end
            6: begin
                s.mon_mult = '0;
                s.ref_mult = '0;
                s.margin = '0;
                s.read_limit = '0;
            end
            default: begin
                s.mon_mask = pick_mask();
                s.mon_mult = pick_mult();
                s.mon_shift = pick_shift();
                s.ref_mask = pick_mask();
                s.ref_mult = pick_mult();
                s.ref_shift = pick_shift();
                s.margin = $urandom >> $urandom_range(0, 31);
                s.read_limit = $urandom >> $urandom_range(0, 31);
            end
        endcase
        return s;
    endfunction

    // Mostly steadily advancing counters with drift, some broken samples, some noise.
    function automatic t_in_req next_sample();
        t_in_req     s;
        logic [63:0] step, drift, win;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick >= 90) begin
            s.mon_count = rand64();
            s.ref_count = rand64();
            s.ref_count_after = $urandom_range(0, 3) == 0 ? s.ref_count : rand64();
            s.sample_time_ns = rand64();
            return s;
        end
        step  = $urandom_range(0, 1 << $urandom_range(0, 24));
        drift = $urandom_range(0, 1 << $urandom_range(0, 18));
        win   = $urandom_range(0, 1 << $urandom_range(0, 17));
        gen_ref = gen_ref + step;
        gen_mon = $urandom_range(0, 1) ? gen_mon + step + drift : gen_mon + step - drift;
        gen_stamp = gen_stamp + $urandom_range(1, 1 << 20);
        if (pick >= 80) begin
            case ($urandom_range(0, 3))
                0: win = rand64() >> $urandom_range(0, 63);
                1: gen_mon = gen_mon - $urandom_range(1, 1 << 20);
                2: gen_ref = gen_ref - $urandom_range(1, 1 << 20);
                default: gen_stamp = gen_stamp - {32'd0, $urandom};
            endcase
        end
        s.mon_count = gen_mon;
        s.ref_count = gen_ref;
        s.ref_count_after = gen_ref + win;
        s.sample_time_ns = gen_stamp;
        return s;
    endfunction

    function automatic void add_row(input logic [63:0] mon, input logic [63:0] refc,
                                    input logic [63:0] after, input logic [63:0] ts,
                                    input bit typed, input logic [2:0] st,
                                    input logic [63:0] mns, input logic [63:0] rns,
                                    input logic [63:0] tot, input logic [31:0] ovf,
                                    input logic [63:0] shortest);
        t_row row;
        row.req.mon_count = mon;
        row.req.ref_count = refc;
        row.req.ref_count_after = after;
        row.req.sample_time_ns = ts;
        row.typed = typed;
        row.rep.status = st;
        row.rep.mon_elapsed_ns = mns;
        row.rep.ref_elapsed_ns = rns;
        row.rep.skew_total_ns = tot;
        row.rep.overflow_total = ovf;
        row.rep.shortest_ns = shortest;
        plan.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endfunction

    // One register write per clock; the caller lowers the enable after a batch.
    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CfgMonMask:   cfg.mon_mask = val;
            CfgMonMult:   cfg.mon_mult = val[31:0];
            CfgMonShift:  cfg.mon_shift = val[5:0];
            CfgRefMask:   cfg.ref_mask = val;
            CfgRefMult:   cfg.ref_mult = val[31:0];
            CfgRefShift:  cfg.ref_shift = val[5:0];
            CfgMargin:    cfg.margin = val[31:0];
            CfgReadLimit: cfg.read_limit = val[31:0];
            default: ;
        endcase
    endtask

    task automatic load_setup(input t_setup s);
        cfg_write(CfgMonMask, s.mon_mask);
        cfg_write(CfgMonMult, {32'd0, s.mon_mult});
        cfg_write(CfgMonShift, {58'd0, s.mon_shift});
        cfg_write(CfgRefMask, s.ref_mask);
        cfg_write(CfgRefMult, {32'd0, s.ref_mult});
        cfg_write(CfgRefShift, {58'd0, s.ref_shift});
        cfg_write(CfgMargin, {32'd0, s.margin});
        cfg_write(CfgReadLimit, {32'd0, s.read_limit});
        i_cfg_we <= 1'b0;
    endtask

    // Drives one request, waits for it to be taken, then maybe idles.
    task automatic offer_sample(input t_in_req s, input bit typed, input t_out_req typed_rep);
        t_out_req rep;
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rep = monitor_sample(s);
        skew_reports.push_back(typed ? typed_rep : rep);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (skew_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result side: check, then pick the next stall pattern
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (skew_reports.size() == 0) begin
                $error("result with no pending request: %0h", o_out_data);
                fault_count++;
            end else begin
                want = skew_reports.pop_front();
                check_field("status", want.status, o_out_data.status);
                check_field("mon_elapsed_ns", want.mon_elapsed_ns, o_out_data.mon_elapsed_ns);
                check_field("ref_elapsed_ns", want.ref_elapsed_ns, o_out_data.ref_elapsed_ns);
                check_field("skew_total_ns", want.skew_total_ns, o_out_data.skew_total_ns);
                check_field("overflow_total", want.overflow_total, o_out_data.overflow_total);
                check_field("shortest_ns", want.shortest_ns, o_out_data.shortest_ns);
            end
        end
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= (rx_tick % 8 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("clock_skew_monitor_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg = default_setup();
        base_mon = '0;
        base_ref = '0;
        base_stamp = '0;
        skew_sum = '0;
        overflow_seen = '0;
        shortest_gap_ns = AllOnes;
        primed_flag = 1'b0;

        // rejected before priming, priming at exactly the limit, overflows, backward steps
        add_row(0, 0, 100001, 0, 1, StReject, 0, 0, 0, 0, AllOnes);
        add_row(1000, 0, 100000, 500, 1, StPrimed, 0, 0, 0, 0, AllOnes);
        add_row(6000, 5000, 5010, 600, 1, StWithin, 5000, 5000, 0, 0, AllOnes);
        add_row(61000, 50000, 50000, 700, 1, StWithin, 60000, 50000, 10000, 0, AllOnes);
        add_row(201000, 100000, 100000, 10500, 1, StShortest, 200000, 100000, 110000, 1,
                10000);
        add_row(201300, 99999, 99999, 10600, 1, StWithin, 300, 0, 300, 1, 10000);
        add_row(0, 100500, 100500, 11000, 1, StWithin, 0, 500, 800, 1, 10000);
        add_row(401000, 100000, 100000, 30500, 1, StExceeded, 200000, 0, 200800, 2, 10000);
        add_row(401100, 300000, 300000, 30600, 1, StShortest, 100, 200000, 199900, 3, 100);
        add_row(401101, 300001, 300000, 30700, 0, StReject, 0, 0, 0, 0, 0);
        add_row(AllOnes, AllOnes, AllOnes, AllOnes, 0, StReject, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, StReject, 0, 0, 0, 0, 0);
        add_row(64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 64'h8000_0000_0000_0000, 0, StReject,
                0, 0, 0, 0, 0);
        add_row(7, 64'h8000_0000_0000_0000, 64'h8000_0000_0001_86A1, 5, 0, StReject,
                0, 0, 0, 0, 0);
        add_row(5, 64'hFFFF_FFFF_FFFF_0000, 64'h10, 3, 0, StReject, 0, 0, 0, 0, 0);
        add_row(128, 64'h0000_0000_0001_D4C0, 64'h0000_0000_0001_D4C0, 1, 0, StReject,
                0, 0, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) offer_sample(plan[k].req, plan[k].typed, plan[k].rep);

        for (int p = 0; p < 12; p++) begin
            settle();
            load_setup(phase_setup(p));
            repeat (83) offer_sample(next_sample(), 1'b0, '0);
        end

        settle();
        if (fault_count == 0) begin
            $display("clock_skew_monitor_top verification clean");
        end else begin
            $display("clock_skew_monitor_top verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/csm_pkg.sv
src/csm_ns_front.sv
src/clock_skew_monitor_top.sv
sim/tb.sv
